// ----- sv/smalu_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, opcode codes and ALU functions for the stack machine ALU.
// Depends on nothing; smalu_div and the top level refer to it by scoped names.
package smalu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WORD_W      = 32;

  // step kinds
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_EXEC = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ  = 3'd3;
  localparam logic [2:0] ERR_UNSUP = 3'd4;

  // opcodes
  localparam logic [7:0] C_ADD  = 8'h00;
  localparam logic [7:0] C_SUB  = 8'h01;
  localparam logic [7:0] C_MUL  = 8'h02;
  localparam logic [7:0] C_SDIV = 8'h03;
  localparam logic [7:0] C_UDIV = 8'h04;
  localparam logic [7:0] C_SMOD = 8'h05;
  localparam logic [7:0] C_UMOD = 8'h06;
  localparam logic [7:0] C_SHL  = 8'h07;
  localparam logic [7:0] C_SHR  = 8'h08;
  localparam logic [7:0] C_SAR  = 8'h09;
  localparam logic [7:0] C_ROL  = 8'h0A;
  localparam logic [7:0] C_ROR  = 8'h0B;
  localparam logic [7:0] C_OR   = 8'h0C;
  localparam logic [7:0] C_AND  = 8'h0D;
  localparam logic [7:0] C_XOR  = 8'h0E;
  localparam logic [7:0] C_EQ   = 8'h0F;
  localparam logic [7:0] C_NE   = 8'h10;
  localparam logic [7:0] C_SLT  = 8'h11;
  localparam logic [7:0] C_SLE  = 8'h12;
  localparam logic [7:0] C_SGT  = 8'h13;
  localparam logic [7:0] C_SGE  = 8'h14;
  localparam logic [7:0] C_ULT  = 8'h15;
  localparam logic [7:0] C_ULE  = 8'h16;
  localparam logic [7:0] C_UGT  = 8'h17;
  localparam logic [7:0] C_UGE  = 8'h18;
  localparam logic [7:0] C_SXB  = 8'h28;
  localparam logic [7:0] C_SXH  = 8'h29;
  localparam logic [7:0] C_ZXB  = 8'h2A;
  localparam logic [7:0] C_ZXH  = 8'h2B;
  localparam logic [7:0] C_NEG  = 8'h30;
  localparam logic [7:0] C_INV  = 8'h31;
  localparam logic [7:0] C_LNOT = 8'h32;
  localparam logic [7:0] C_EQZ  = 8'h33;
  localparam logic [7:0] C_NEZ  = 8'h34;
  localparam logic [7:0] C_LTZ  = 8'h35;
  localparam logic [7:0] C_LEZ  = 8'h36;
  localparam logic [7:0] C_GTZ  = 8'h37;
  localparam logic [7:0] C_GEZ  = 8'h38;

  function automatic logic is_binary(input logic [7:0] code);
    is_binary = (code <= C_UGE);
  endfunction

  function automatic logic is_unary(input logic [7:0] code);
    is_unary = ((code >= C_SXB) && (code <= C_ZXH)) || ((code >= C_NEG) && (code <= C_GEZ));
  endfunction

  function automatic logic is_divide(input logic [7:0] code);
    is_divide = (code >= C_SDIV) && (code <= C_UMOD);
  endfunction

  // Everything binary except the divide group, which goes to the divider.
  function automatic logic [31:0] binary_result(input logic [7:0] code,
                                               input logic [31:0] l,
                                               input logic [31:0] r);
    logic [4:0]  s;
    logic [63:0] rl;
    logic [63:0] rr;
    logic        slt;
    logic        sgt;
    s   = r[4:0];
    rl  = {l, l} << s;
    rr  = {l, l} >> s;
    slt = $signed(l) < $signed(r);
    sgt = $signed(l) > $signed(r);
    case (code)
      C_ADD:   binary_result = l + r;
      C_SUB:   binary_result = l - r;
      C_MUL:   binary_result = l * r;
      C_SHL:   binary_result = l << s;
      C_SHR:   binary_result = l >> s;
      C_SAR:   binary_result = 32'($signed(l) >>> s);
      C_ROL:   binary_result = rl[63:32];
      C_ROR:   binary_result = rr[31:0];
      C_OR:    binary_result = l | r;
      C_AND:   binary_result = l & r;
      C_XOR:   binary_result = l ^ r;
      C_EQ:    binary_result = {31'd0, l == r};
      C_NE:    binary_result = {31'd0, l != r};
      C_SLT:   binary_result = {31'd0, slt};
      C_SLE:   binary_result = {31'd0, !sgt};
      C_SGT:   binary_result = {31'd0, sgt};
      C_SGE:   binary_result = {31'd0, !slt};
      C_ULT:   binary_result = {31'd0, l < r};
      C_ULE:   binary_result = {31'd0, l <= r};
      C_UGT:   binary_result = {31'd0, l > r};
      default: binary_result = {31'd0, l >= r};
    endcase
  endfunction

  function automatic logic [31:0] unary_result(input logic [7:0] code, input logic [31:0] v);
    logic neg;
    logic zero;
    neg  = v[31];
    zero = (v == 32'd0);
    case (code)
      C_SXB:   unary_result = {{24{v[7]}}, v[7:0]};
      C_SXH:   unary_result = {{16{v[15]}}, v[15:0]};
      C_ZXB:   unary_result = {24'd0, v[7:0]};
      C_ZXH:   unary_result = {16'd0, v[15:0]};
      C_NEG:   unary_result = 32'd0 - v;
      C_INV:   unary_result = ~v;
      C_LNOT:  unary_result = {31'd0, zero};
      C_EQZ:   unary_result = {31'd0, zero};
      C_NEZ:   unary_result = {31'd0, !zero};
      C_LTZ:   unary_result = {31'd0, neg};
      C_LEZ:   unary_result = {31'd0, neg || zero};
      C_GTZ:   unary_result = {31'd0, !neg && !zero};
      default: unary_result = {31'd0, !neg};
    endcase
  endfunction

endpackage

// ----- sv/smalu_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module smalu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/smalu_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on smalu_pkg for the word width.
module smalu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quot,
  output logic [31:0] rem,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] b_r, b_nxt;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[smalu_pkg::WORD_W-1]} - {1'b0, b_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = 5'd0;
      q_nxt    = dividend;
      rem_nxt  = 32'd0;
      b_nxt    = divisor;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
  end

  assign quot = q_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ----- sv/stack_machine_integer_alu.sv -----
`timescale 1ns / 1ps
// Stack machine integer ALU: 32-bit operand stack in a synchronous RAM with a
// cached top-of-stack register, an integer ALU and an iterative divider.
// Depends on smalu_pkg, smalu_ram and smalu_div.
//
// Usage:
//   The input channel (in_*) carries one transaction per step: push a word,
//   pop the top word, or execute a no-argument ALU opcode. The result channel
//   (out_*) returns exactly one transaction per step with the top value, the
//   stack depth and an error code.
//   Flow: a step is accepted in the idle state and the stack RAM is read in
//   that cycle; the RAM read port is registered, so the result is computed in
//   the execute state and registered once the output register is free. Divide
//   and modulo run through a one bit per cycle divider and wait in the divide
//   state until it is done and the output register is free.
//   One step is in flight at a time; a new transaction is accepted while the
//   previous result still waits in the output register.
//   Reset empties the stack (count goes to zero) and drops any pending result;
//   no clearing pass runs, the RAM is never read below an unwritten entry.
//   When the receiver stalls, the result holds in the output register and the
//   next step, once accepted, waits before it commits to the stack.
module stack_machine_integer_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] alu_code, [39:8] push_value
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] top_value, [40:32] depth, [47:41] zero
  output logic [2:0]  out_tuser   // [2:0] error_code
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam int CW = smalu_pkg::CNT_W;
  localparam int AW = smalu_pkg::ADDR_W;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   top_r, top_nxt;
  logic [1:0]    op_r;
  logic [7:0]    code_r;
  logic [31:0]   pv_r;
  logic          an_r, an_nxt;
  logic          bn_r, bn_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_top_r, out_top_nxt;
  logic [CW-1:0] out_depth_r, out_depth_nxt;
  logic [2:0]    out_err_r, out_err_nxt;

  logic          in_fire;
  logic          slot_free;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic          div_start;
  logic [31:0]   div_a;
  logic [31:0]   div_b;
  logic [31:0]   div_q;
  logic [31:0]   div_r;
  logic          div_done;
  logic [31:0]   lhs;
  logic [31:0]   rhs;
  logic [31:0]   div_res;
  logic [31:0]   err_top;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  // the entry below the top; count is steady from accept until commit
  assign raddr     = cnt_m2[AW-1:0];
  assign lhs       = rdata;
  assign rhs       = top_r;
  assign err_top   = (count_r != '0) ? top_r : 32'd0;

  smalu_ram #(
    .WIDTH(smalu_pkg::WORD_W),
    .DEPTH(smalu_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  smalu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quot     (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  // signed divide fixes: quotient sign is an^bn, remainder follows dividend
  always_comb begin
    case (code_r)
      smalu_pkg::C_SDIV: div_res = (an_r != bn_r) ? (32'd0 - div_q) : div_q;
      smalu_pkg::C_SMOD: div_res = an_r ? (32'd0 - div_r) : div_r;
      smalu_pkg::C_UDIV: div_res = div_q;
      default:           div_res = div_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    an_nxt        = an_r;
    bn_nxt        = bn_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_top_nxt   = out_top_r;
    out_depth_nxt = out_depth_r;
    out_err_nxt   = out_err_r;
    we            = 1'b0;
    waddr         = cnt_m2[AW-1:0];
    wdata         = 32'd0;
    div_start     = 1'b0;
    div_a         = lhs;
    div_b         = rhs;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // divider launch does not need the output slot
        if (op_r == smalu_pkg::OP_EXEC && smalu_pkg::is_divide(code_r) &&
            count_r >= CW'(2) && rhs != 32'd0) begin
          an_nxt    = (code_r == smalu_pkg::C_SDIV || code_r == smalu_pkg::C_SMOD) && lhs[31];
          bn_nxt    = (code_r == smalu_pkg::C_SDIV || code_r == smalu_pkg::C_SMOD) && rhs[31];
          div_a     = an_nxt ? (32'd0 - lhs) : lhs;
          div_b     = bn_nxt ? (32'd0 - rhs) : rhs;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_err_nxt   = smalu_pkg::ERR_OK;
          out_top_nxt   = err_top;
          out_depth_nxt = count_r;
          case (op_r)
            smalu_pkg::OP_PUSH: begin
              if (count_r == CW'(smalu_pkg::STACK_DEPTH)) begin
                out_err_nxt = smalu_pkg::ERR_OVER;
              end else begin
                we            = 1'b1;
                waddr         = count_r[AW-1:0];
                wdata         = pv_r;
                top_nxt       = pv_r;
                count_nxt     = count_r + CW'(1);
                out_top_nxt   = pv_r;
                out_depth_nxt = count_r + CW'(1);
              end
            end
            smalu_pkg::OP_POP: begin
              if (count_r == '0) begin
                out_err_nxt = smalu_pkg::ERR_UNDER;
              end else begin
                out_top_nxt   = top_r;
                out_depth_nxt = cnt_m1;
                count_nxt     = cnt_m1;
                top_nxt       = (count_r >= CW'(2)) ? lhs : 32'd0;
              end
            end
            smalu_pkg::OP_EXEC: begin
              if (smalu_pkg::is_binary(code_r)) begin
                if (count_r < CW'(2)) begin
                  out_err_nxt = smalu_pkg::ERR_UNDER;
                end else if (smalu_pkg::is_divide(code_r)) begin
                  // only reached with a zero divisor
                  out_err_nxt = smalu_pkg::ERR_DIVZ;
                end else begin
                  wdata         = smalu_pkg::binary_result(code_r, lhs, rhs);
                  we            = 1'b1;
                  waddr         = cnt_m2[AW-1:0];
                  top_nxt       = wdata;
                  count_nxt     = cnt_m1;
                  out_top_nxt   = wdata;
                  out_depth_nxt = cnt_m1;
                end
              end else if (smalu_pkg::is_unary(code_r)) begin
                if (count_r == '0) begin
                  out_err_nxt = smalu_pkg::ERR_UNDER;
                end else begin
                  wdata       = smalu_pkg::unary_result(code_r, top_r);
                  we          = 1'b1;
                  waddr       = cnt_m1[AW-1:0];
                  top_nxt     = wdata;
                  out_top_nxt = wdata;
                end
              end else begin
                out_err_nxt = smalu_pkg::ERR_UNSUP;
              end
            end
            default: begin
              out_err_nxt = smalu_pkg::ERR_UNSUP;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (div_done && slot_free) begin
          we            = 1'b1;
          waddr         = cnt_m2[AW-1:0];
          wdata         = div_res;
          top_nxt       = div_res;
          count_nxt     = cnt_m1;
          out_valid_nxt = 1'b1;
          out_top_nxt   = div_res;
          out_depth_nxt = cnt_m1;
          out_err_nxt   = smalu_pkg::ERR_OK;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r       <= top_nxt;
    an_r        <= an_nxt;
    bn_r        <= bn_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_err_r   <= out_err_nxt;
    if (in_fire) begin
      op_r   <= in_tuser;
      code_r <= in_tdata[7:0];
      pv_r   <= in_tdata[39:8];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, 9'(out_depth_r), out_top_r};
  assign out_tuser  = out_err_r;

  // stack count never passes the stack size
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(smalu_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  // the divider is only waited on for an execute step of the divide group
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (op_r == smalu_pkg::OP_EXEC && smalu_pkg::is_divide(code_r)))
    else $error("divide wait without divide opcode");

  // an overflow result is only reported on a full stack
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == smalu_pkg::ERR_OVER) |->
      (count_r == CW'(smalu_pkg::STACK_DEPTH)))
    else $error("overflow reported on non-full stack");

  // a commit to the stack never overwrites a result still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r != ST_IDLE) |-> slot_free)
    else $error("stack written while output stalled");

endmodule
